// ===== rtl/frc255_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frc255_pkg: shared types and constants
// Phase and status codes, the result record and the modulo-255 byte adder
// used by the frame receiver.
// ----------------------------------------------------------------------------
package frc255_pkg;

	localparam logic [15:0] MAX_PAYLOAD = 16'd64;
	localparam logic [7:0]  HDR_BYTE    = 8'hFF;
	localparam logic [8:0]  SUM_MOD     = 9'd255;

	// Register select taken from paddr[2].
	localparam logic REG_OWN_ID  = 1'b0;
	localparam logic REG_PEER_ID = 1'b1;

	typedef enum logic [2:0] {
		PH_HDR1     = 3'd0,
		PH_HDR2     = 3'd1,
		PH_SENDER   = 3'd2,
		PH_RECEIVER = 3'd3,
		PH_LENH     = 3'd4,
		PH_LENL     = 3'd5,
		PH_DATA     = 3'd6,
		PH_CHECK    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY         = 3'd0,
		ST_GOOD         = 3'd1,
		ST_SENDER_BAD   = 3'd2,
		ST_RECEIVER_BAD = 3'd3,
		ST_CHECK_BAD    = 3'd4,
		ST_TOO_LONG     = 3'd5
	} status_t;

	typedef struct packed {
		status_t     status;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [5:0]  payload_index;
		logic [6:0]  frame_length;
		logic [15:0] good_frames;
	} result_t;

	// Running sum kept in 0..254. The raw sum stays below 510, so a single
	// conditional subtract is enough.
	function automatic logic [7:0] sum_mod255(input logic [7:0] acc, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, acc} + {1'b0, b};
		if (s >= SUM_MOD) begin
			s = s - SUM_MOD;
		end
		return s[7:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/frc255_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frc255_parse: frame parser state
// Holds the frame phase, running checksum, declared length, payload count and
// good-frame counter; gives the result for the byte at its input and advances
// its state when that byte is consumed.
// ----------------------------------------------------------------------------
module frc255_parse
	import frc255_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         en,
	input  wire  [7:0]  rx_byte,
	input  wire  [7:0]  own_id,
	input  wire  [7:0]  peer_id,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] len_q, len_d;
	logic [6:0]  taken_q, taken_d;
	logic [15:0] count_q, count_d;

	logic [7:0]  sum_add;
	logic [15:0] len_full;
	logic [6:0]  taken_inc;

	assign sum_add   = sum_mod255(sum_q, rx_byte);
	assign len_full  = {len_q[15:8], rx_byte};
	assign taken_inc = taken_q + 7'd1;

	// Next state
	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		len_d   = len_q;
		taken_d = taken_q;
		count_d = count_q;
		case (phase_q)
			PH_HDR1: begin
				if (rx_byte == HDR_BYTE) begin
					// A fresh frame: the sum of a single 0xFF is zero.
					sum_d   = sum_mod255(8'd0, rx_byte);
					len_d   = 16'd0;
					taken_d = 7'd0;
					phase_d = PH_HDR2;
				end
			end
			PH_HDR2: begin
				if (rx_byte == HDR_BYTE) begin
					sum_d   = sum_add;
					phase_d = PH_SENDER;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_SENDER: begin
				if (rx_byte == peer_id) begin
					sum_d   = sum_add;
					phase_d = PH_RECEIVER;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_RECEIVER: begin
				if (rx_byte == own_id) begin
					sum_d   = sum_add;
					phase_d = PH_LENH;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_LENH: begin
				sum_d   = sum_add;
				len_d   = {rx_byte, 8'd0};
				phase_d = PH_LENL;
			end
			PH_LENL: begin
				sum_d   = sum_add;
				len_d   = len_full;
				phase_d = (len_full > MAX_PAYLOAD) ? PH_HDR1 : PH_DATA;
			end
			PH_DATA: begin
				sum_d   = sum_add;
				taken_d = taken_inc;
				// A zero length still takes one payload byte.
				if ({9'd0, taken_inc} >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (rx_byte == sum_q) begin
					count_d = count_q + 16'd1;
				end
				sum_d   = 8'd0;
				phase_d = PH_HDR1;
			end
			default: begin
				phase_d = PH_HDR1;
			end
		endcase
	end

	// Result for the current byte
	always_comb begin
		res               = '0;
		res.status        = ST_BUSY;
		res.good_frames   = count_d;
		case (phase_q)
			PH_SENDER: begin
				if (rx_byte != peer_id) begin
					res.status = ST_SENDER_BAD;
				end
			end
			PH_RECEIVER: begin
				if (rx_byte != own_id) begin
					res.status = ST_RECEIVER_BAD;
				end
			end
			PH_LENL: begin
				if (len_full > MAX_PAYLOAD) begin
					res.status = ST_TOO_LONG;
				end
			end
			PH_DATA: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = taken_q[5:0];
			end
			PH_CHECK: begin
				if (rx_byte == sum_q) begin
					res.status       = ST_GOOD;
					res.frame_length = len_q[6:0];
				end else begin
					res.status = ST_CHECK_BAD;
				end
			end
			default: begin
				res.status = ST_BUSY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			sum_q   <= 8'd0;
			len_q   <= 16'd0;
			taken_q <= 7'd0;
			count_q <= 16'd0;
		end else if (en) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			taken_q <= taken_d;
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/frame_receiver_checksum_255_unit.sv =====
`default_nettype none
// Path: an accepted byte is held in the input stage, then its result is registered in
// the result stage. Throughput: one byte per cycle while m_tready does not stall it.
// The input stage and the result stage each hold one beat, so the input side
// takes one more byte while a finished result waits for m_tready.
// Reset: arst_n clears both stages, the parser state, the good-frame counter
// and the id registers to zero; the parser starts hunting for the header.
// ----------------------------------------------------------------------------
// frame_receiver_checksum_255_unit: serial frame receiver top level
// Byte stream in, one result beat per byte out, APB port for the node ids.
// ----------------------------------------------------------------------------
module frame_receiver_checksum_255_unit
	import frc255_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	// APB configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Byte input
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	// Result output
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [2:0] status, [10:3] payload_byte,
	                               // [16:11] payload_index, [23:17] frame_length,
	                               // [39:24] good_frames
	output logic        m_tuser    // [0] payload_valid
);

	logic [7:0] own_id_q, peer_id_q;
	logic       valid_s1, valid_s2;
	logic [7:0] byte_s1;
	result_t    res_s2, res;
	logic       adv;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= 8'd0;
			peer_id_q <= 8'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_OWN_ID:  own_id_q  <= pwdata[7:0];
				REG_PEER_ID: peer_id_q <= pwdata[7:0];
				default:     own_id_q  <= own_id_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OWN_ID:  prdata = {24'd0, own_id_q};
			REG_PEER_ID: prdata = {24'd0, peer_id_q};
			default:     prdata = 32'd0;
		endcase
	end

	// Stage 1 moves into stage 2 when stage 2 is empty or is being drained.
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	frc255_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rx_byte (byte_s1),
		.own_id  (own_id_q),
		.peer_id (peer_id_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.payload_valid;
	assign m_tdata  = {res_s2.good_frames, res_s2.frame_length, res_s2.payload_index,
	                   res_s2.payload_byte, res_s2.status};

	// A payload beat never carries a final status.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[2:0] == ST_BUSY)
		else $error("payload beat carries a frame status");

	// A good frame never declares more than the maximum payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == ST_GOOD |-> {9'd0, m_tdata[23:17]} <= MAX_PAYLOAD)
		else $error("good frame with oversize length");

	// A byte held in the input stage is not dropped while the result stage stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a byte");

	// A stalled result beat keeps its good-frame count.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |=> $stable(res_s2.good_frames))
		else $error("good-frame count changed under a stalled beat");

endmodule
`default_nettype wire

// ===== tb/frame_receiver_checksum_255_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_receiver_checksum_255_unit_tb: self-checking bench for the frame receiver
// Feeds byte streams made of well-formed frames, frames with bad ids, lengths
// or checksums, truncated frames and line noise. Every byte beat is run
// through a local parser model, and each result beat is compared field by
// field. Node ids are rewritten over the APB port between traffic phases, and
// the phases cycle through four pacings of the byte and result handshakes.
// ----------------------------------------------------------------------------
module frame_receiver_checksum_255_unit_tb;
	import frc255_pkg::*;

	localparam logic [2:0] ADDR_OWN_ID   = {REG_OWN_ID, 2'b00};
	localparam logic [2:0] ADDR_PEER_ID  = {REG_PEER_ID, 2'b00};
	localparam int         BYTES_PER_RUN = 175;
	localparam int         NUM_RUNS      = 8;

	// Checksum field choices for a generated frame.
	localparam int CS_RIGHT = 0;
	localparam int CS_WRONG = 1;
	localparam int CS_ALL_ONES = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // [2:0] status, [10:3] payload_byte,
	                               // [16:11] payload_index, [23:17] frame_length,
	                               // [39:24] good_frames
	logic        m_tuser;          // [0] payload_valid

	frame_receiver_checksum_255_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes waiting to be sent and results waiting to come back.
	logic [7:0] tx_bytes [$];
	result_t    pending_results [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic in_taken = 1'b0;

	int mismatches = 0;
	int bytes_queued = 0;
	int bytes_accepted = 0;
	int frames_good = 0;
	int frames_rejected = 0;
	int payload_beats = 0;

	// Parser model state and its copy of the id registers.
	phase_t      rx_phase = PH_HDR1;
	logic [7:0]  rx_sum = '0;
	logic [15:0] rx_len = '0;
	logic [6:0]  rx_taken = '0;
	logic [15:0] good_count = '0;
	logic [7:0]  own_id_reg = '0;
	logic [7:0]  peer_id_reg = '0;

	function automatic logic [7:0] add_mod255(input logic [7:0] acc, input logic [7:0] b);
		return 8'((int'(acc) + int'(b)) % 255);
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.status = ST_BUSY;
		case (rx_phase)
			PH_HDR1: begin
				if (b == HDR_BYTE) begin
					rx_len = '0;
					rx_taken = '0;
					rx_sum = add_mod255(8'd0, b);
					rx_phase = PH_HDR2;
				end
			end
			PH_HDR2: begin
				// A stray byte here is not retried as a first header byte.
				if (b == HDR_BYTE) begin
					rx_sum = add_mod255(rx_sum, b);
					rx_phase = PH_SENDER;
				end else begin
					rx_phase = PH_HDR1;
				end
			end
			PH_SENDER: begin
				if (b == peer_id_reg) begin
					rx_sum = add_mod255(rx_sum, b);
					rx_phase = PH_RECEIVER;
				end else begin
					r.status = ST_SENDER_BAD;
					rx_phase = PH_HDR1;
				end
			end
			PH_RECEIVER: begin
				if (b == own_id_reg) begin
					rx_sum = add_mod255(rx_sum, b);
					rx_phase = PH_LENH;
				end else begin
					r.status = ST_RECEIVER_BAD;
					rx_phase = PH_HDR1;
				end
			end
			PH_LENH: begin
				rx_sum = add_mod255(rx_sum, b);
				rx_len = {b, 8'd0};
				rx_phase = PH_LENL;
			end
			PH_LENL: begin
				rx_sum = add_mod255(rx_sum, b);
				rx_len = {rx_len[15:8], b};
				if (rx_len > MAX_PAYLOAD) begin
					r.status = ST_TOO_LONG;
					rx_phase = PH_HDR1;
				end else begin
					rx_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				// A zero length still takes one payload byte.
				rx_sum = add_mod255(rx_sum, b);
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.payload_index = rx_taken[5:0];
				rx_taken = rx_taken + 7'd1;
				if ({9'd0, rx_taken} >= rx_len) begin
					rx_phase = PH_CHECK;
				end
			end
			default: begin
				// The sum never reaches 255, so an all-ones checksum always fails.
				if (b == rx_sum) begin
					r.status = ST_GOOD;
					r.frame_length = rx_len[6:0];
					good_count = good_count + 16'd1;
				end else begin
					r.status = ST_CHECK_BAD;
				end
				rx_sum = '0;
				rx_phase = PH_HDR1;
			end
		endcase
		r.good_frames = good_count;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
	                                    input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Byte driver: a beat that was offered stays put until it is taken.
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !in_taken)) begin
			if (tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= tx_bytes[0];
			end else begin
				s_tvalid <= 1'b0;
				s_tdata <= 8'($urandom);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no byte outstanding: m_tdata 0x%0h", m_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 16'(want.status), 16'(m_tdata[2:0]));
					check_field("payload_valid", 16'(want.payload_valid), 16'(m_tuser));
					check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[10:3]));
					check_field("payload_index", 16'(want.payload_index), 16'(m_tdata[16:11]));
					check_field("frame_length", 16'(want.frame_length), 16'(m_tdata[23:17]));
					check_field("good_frames", want.good_frames, m_tdata[39:24]);
					if (want.status == ST_GOOD) begin
						frames_good++;
					end else if (want.status != ST_BUSY) begin
						frames_rejected++;
					end
					if (want.payload_valid) begin
						payload_beats++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pending_results.push_back(parse_byte(s_tdata));
				void'(tx_bytes.pop_front());
				bytes_accepted++;
			end
			in_taken <= s_tvalid && s_tready;
		end else begin
			in_taken <= 1'b0;
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_OWN_ID) begin
			own_id_reg = value;
		end else begin
			peer_id_reg = value;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic push_byte(input logic [7:0] b);
		tx_bytes.push_back(b);
		bytes_queued++;
	endtask

	// Queues one frame; an oversize length ends it after the length bytes.
	// A negative fill gives random payload bytes.
	task automatic push_frame(input logic [7:0] snd, input logic [7:0] rcv,
	                          input logic [15:0] len, input int fill, input int cs_mode);
		logic [7:0] head [6];
		logic [7:0] pb;
		int acc;
		int n;
		head = '{HDR_BYTE, HDR_BYTE, snd, rcv, len[15:8], len[7:0]};
		acc = 0;
		foreach (head[i]) begin
			push_byte(head[i]);
			acc = (acc + head[i]) % 255;
		end
		if (len > MAX_PAYLOAD) begin
			return;
		end
		n = (len == 16'd0) ? 1 : int'(len);
		repeat (n) begin
			pb = (fill < 0) ? 8'($urandom) : 8'(fill);
			push_byte(pb);
			acc = (acc + pb) % 255;
		end
		case (cs_mode)
			CS_RIGHT: push_byte(8'(acc));
			CS_WRONG: push_byte(8'((acc + $urandom_range(1, 254)) % 255));
			default:  push_byte(8'hFF);
		endcase
	endtask

	task automatic push_random_traffic();
		int kind;
		int pick;
		int cs_mode;
		logic [15:0] len;
		logic [7:0] snd;
		logic [7:0] rcv;
		kind = $urandom_range(99);
		pick = $urandom_range(99);
		snd = peer_id_reg;
		rcv = own_id_reg;
		if (pick < 3) begin
			len = MAX_PAYLOAD;
		end else if (pick < 8) begin
			len = 16'($urandom_range(9, 63));
		end else begin
			len = 16'($urandom_range(0, 8));
		end
		pick = $urandom_range(19);
		cs_mode = (pick == 0) ? CS_WRONG : (pick == 1) ? CS_ALL_ONES : CS_RIGHT;
		if (kind < 70) begin
			push_frame(snd, rcv, len, -1, cs_mode);
		end else if (kind < 76) begin
			if ($urandom_range(1)) begin
				snd = snd ^ 8'($urandom_range(1, 255));
			end else begin
				rcv = rcv ^ 8'($urandom_range(1, 255));
			end
			push_frame(snd, rcv, len, -1, cs_mode);
		end else if (kind < 82) begin
			len = $urandom_range(1) ? 16'($urandom_range(65, 255))
			                        : 16'($urandom_range(256, 65535));
			push_frame(snd, rcv, len, -1, cs_mode);
		end else if (kind < 90) begin
			// A frame cut short: header followed by whatever comes next.
			push_byte(HDR_BYTE);
			push_byte(HDR_BYTE);
			repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (tx_bytes.size() != 0 || pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int run_start;
		logic [7:0] own_val;
		logic [7:0] peer_val;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed bytes with both ids at their reset value of zero.
		push_frame(8'h00, 8'h00, 16'd0, 8'hFF, CS_RIGHT);
		push_byte(HDR_BYTE);
		push_byte(8'h00);
		push_byte(HDR_BYTE);
		push_byte(HDR_BYTE);
		push_byte(8'h01);
		push_byte(HDR_BYTE);
		push_byte(HDR_BYTE);
		push_byte(8'h00);
		push_byte(8'h07);
		push_frame(8'h00, 8'h00, MAX_PAYLOAD + 16'd1, 0, CS_RIGHT);
		push_frame(8'h00, 8'h00, 16'd0, 8'h00, CS_ALL_ONES);
		wait_drained();

		for (int run = 0; run < NUM_RUNS; run++) begin
			case (run)
				0: begin own_val = 8'hA5; peer_val = 8'h3C; end
				1: begin own_val = 8'hFF; peer_val = 8'hFF; end
				2: begin own_val = 8'h00; peer_val = 8'hFF; end
				3: begin own_val = 8'hFF; peer_val = 8'h00; end
				5: begin own_val = 8'h00; peer_val = 8'h00; end
				7: begin own_val = 8'h5A; peer_val = 8'hC3; end
				default: begin
					own_val = 8'($urandom);
					peer_val = 8'($urandom);
				end
			endcase
			write_reg(ADDR_OWN_ID, own_val);
			write_reg(ADDR_PEER_ID, peer_val);
			case (run % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			run_start = bytes_queued;
			while (bytes_queued - run_start < BYTES_PER_RUN) begin
				push_random_traffic();
			end
			wait_drained();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes over %0d id settings and four pacing modes.",
		         bytes_accepted, NUM_RUNS + 1);
		$display("Frames accepted: %0d, frames rejected: %0d, payload beats: %0d.",
		         frames_good, frames_rejected, payload_beats);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
